FILE: hw/rtl/bsap_header_extractor_defines.svh
// assertion helpers for the header extractor
`ifndef BSAP_HEADER_EXTRACTOR_DEFINES_SVH
`define BSAP_HEADER_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSAP_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked out of reset
`define BSAP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/bsap_pkg.sv
package bsap_pkg;

    localparam int unsigned POS_W = 16;
    localparam logic [POS_W-1:0] MAX_PAYLOAD_BYTES = 16'hFFFF;

    localparam logic [15:0] TUNNEL_MAGIC = 16'h0210;
    localparam int unsigned GLOBAL_BIT = 7;
    localparam logic [7:0]  NAK_CODE = 8'h95;

    localparam logic [POS_W-1:0] NATIVE_HDR = 16'd4;
    localparam logic [POS_W-1:0] LOCAL_HDR  = 16'd9;
    localparam logic [POS_W-1:0] GLOBAL_HDR = 16'd14;
    localparam logic [POS_W-1:0] LEAD_LEN   = 16'd2;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_SHORT  = 2'd0;
    localparam t_kind KIND_NATIVE = 2'd1;
    localparam t_kind KIND_LOCAL  = 2'd2;
    localparam t_kind KIND_GLOBAL = 2'd3;

endpackage

FILE: hw/rtl/bsap_header_extractor.sv
// header extractor for frames carried in a udp payload
// input channel: one payload byte per request on i_data_byte, with
//   i_last_byte marking the final byte; i_valid / o_stall handshake
// output channel: one result per payload, presented on the o_ field ports
//   with o_valid; the receiver holds it with i_stall
// a byte is registered in the input register when accepted and folded
//   into the parse state from there; a payload's result is loaded into
//   the result register (o_valid) as its last byte leaves the input register
// throughput is one byte per cycle unless a final byte waits; a new
//   byte is taken while a result still waits at the output register
// when the receiver stalls, the result holds; non-final bytes keep
//   flowing, and only a final byte waits, raising o_stall until the
//   output register frees up
// reset clears the byte counter, all parse field registers and both
//   valid flags; after each final byte the field state clears again
module bsap_header_extractor
    import bsap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_kind,
    output logic [6:0]  o_node_address,
    output logic [7:0]  o_serial_number,
    output logic [15:0] o_first_word,
    output logic [15:0] o_second_word,
    output logic [7:0]  o_control_byte,
    output logic [7:0]  o_dest_function,
    output logic [15:0] o_sequence_number,
    output logic [7:0]  o_src_function,
    output logic [7:0]  o_node_status,
    output logic [15:0] o_trailing_count,
    output logic        o_nak_seen
);

`include "bsap_header_extractor_defines.svh"

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    // parse state
    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_lead;
    logic [7:0]       r_addr;
    logic [7:0]       r_ser;
    logic [15:0]      r_word_a;
    logic [15:0]      r_word_b;
    logic [7:0]       r_ctl;
    logic [7:0]       r_dfun;
    logic [15:0]      r_seq;
    logic [7:0]       r_sfun;
    logic [7:0]       r_nsb;

    // state with the current byte folded in
    logic [POS_W-1:0] n_pos;
    logic [15:0]      n_lead;
    logic [7:0]       n_addr;
    logic [7:0]       n_ser;
    logic [15:0]      n_word_a;
    logic [15:0]      n_word_b;
    logic [7:0]       n_ctl;
    logic [7:0]       n_dfun;
    logic [15:0]      n_seq;
    logic [7:0]       n_sfun;
    logic [7:0]       n_nsb;

    // result register
    logic             r_out_valid;
    t_kind            r_kind;
    logic [6:0]       r_node_address;
    logic [7:0]       r_serial_number;
    logic [15:0]      r_first_word;
    logic [15:0]      r_second_word;
    logic [7:0]       r_control_byte;
    logic [7:0]       r_dest_function;
    logic [15:0]      r_sequence_number;
    logic [7:0]       r_src_function;
    logic [7:0]       r_node_status;
    logic [15:0]      r_trailing_count;
    logic             r_nak_seen;

    // result from the folded state
    t_kind            res_kind;
    logic [6:0]       res_node_address;
    logic [7:0]       res_serial_number;
    logic [15:0]      res_first_word;
    logic [15:0]      res_second_word;
    logic [7:0]       res_control_byte;
    logic [7:0]       res_dest_function;
    logic [15:0]      res_sequence_number;
    logic [7:0]       res_src_function;
    logic [7:0]       res_node_status;
    logic [15:0]      res_trailing_count;
    logic             res_nak_seen;

    logic             out_free;
    logic             advance;
    logic             in_accept;
    logic             out_load;
    logic             is_tunnel;
    logic             addr_glob;
    logic             res_global;
    logic [POS_W-1:0] hdr_len;

    // handshake
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && (!r_in_last || out_free);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;
    assign out_load  = advance && r_in_last;

    // field capture by byte position
    assign is_tunnel = (r_lead == TUNNEL_MAGIC);
    assign addr_glob = r_addr[GLOBAL_BIT];

    always_comb begin
        n_lead   = r_lead;
        n_addr   = r_addr;
        n_ser    = r_ser;
        n_word_a = r_word_a;
        n_word_b = r_word_b;
        n_ctl    = r_ctl;
        n_dfun   = r_dfun;
        n_seq    = r_seq;
        n_sfun   = r_sfun;
        n_nsb    = r_nsb;
        case (r_pos)
            16'd0: n_lead[7:0]  = r_in_byte;
            16'd1: n_lead[15:8] = r_in_byte;
            16'd2: begin
                if (is_tunnel) begin
                    n_addr = r_in_byte;
                end else begin
                    n_word_b[7:0] = r_in_byte;
                end
            end
            16'd3: begin
                if (is_tunnel) begin
                    n_ser = r_in_byte;
                end else begin
                    n_word_b[15:8] = r_in_byte;
                end
            end
            16'd4: begin
                if (is_tunnel && addr_glob) begin
                    n_word_a[7:0] = r_in_byte;
                end else if (is_tunnel) begin
                    n_dfun = r_in_byte;
                end
            end
            16'd5: begin
                if (is_tunnel && addr_glob) begin
                    n_word_a[15:8] = r_in_byte;
                end else if (is_tunnel) begin
                    n_seq[7:0] = r_in_byte;
                end
            end
            16'd6: begin
                if (is_tunnel && addr_glob) begin
                    n_word_b[7:0] = r_in_byte;
                end else if (is_tunnel) begin
                    n_seq[15:8] = r_in_byte;
                end
            end
            16'd7: begin
                if (is_tunnel && addr_glob) begin
                    n_word_b[15:8] = r_in_byte;
                end else if (is_tunnel) begin
                    n_sfun = r_in_byte;
                end
            end
            16'd8: begin
                if (is_tunnel && addr_glob) begin
                    n_ctl = r_in_byte;
                end else if (is_tunnel) begin
                    n_nsb = r_in_byte;
                end
            end
            16'd9:  if (is_tunnel && addr_glob) n_dfun       = r_in_byte;
            16'd10: if (is_tunnel && addr_glob) n_seq[7:0]   = r_in_byte;
            16'd11: if (is_tunnel && addr_glob) n_seq[15:8]  = r_in_byte;
            16'd12: if (is_tunnel && addr_glob) n_sfun       = r_in_byte;
            16'd13: if (is_tunnel && addr_glob) n_nsb        = r_in_byte;
            default: ;
        endcase
    end

    // byte count saturates at the payload limit
    assign n_pos = (r_pos < MAX_PAYLOAD_BYTES) ? r_pos + 1'b1 : r_pos;

    // result decode
    assign res_global = n_addr[GLOBAL_BIT];
    assign hdr_len    = res_global ? GLOBAL_HDR : LOCAL_HDR;

    always_comb begin
        res_kind            = KIND_SHORT;
        res_node_address    = '0;
        res_serial_number   = '0;
        res_first_word      = '0;
        res_second_word     = '0;
        res_control_byte    = '0;
        res_dest_function   = '0;
        res_sequence_number = '0;
        res_src_function    = '0;
        res_node_status     = '0;
        res_trailing_count  = '0;
        res_nak_seen        = 1'b0;
        if (n_pos >= LEAD_LEN) begin
            if (n_lead == TUNNEL_MAGIC) begin
                if (n_pos >= hdr_len) begin
                    res_kind            = res_global ? KIND_GLOBAL : KIND_LOCAL;
                    res_node_address    = n_addr[6:0];
                    res_serial_number   = n_ser;
                    if (res_global) begin
                        res_first_word   = n_word_a;
                        res_second_word  = n_word_b;
                        res_control_byte = n_ctl;
                    end
                    res_dest_function   = n_dfun;
                    res_sequence_number = n_seq;
                    res_src_function    = n_sfun;
                    res_node_status     = n_nsb;
                    res_trailing_count  = n_pos - hdr_len;
                    res_nak_seen        = (n_dfun == NAK_CODE) || (n_sfun == NAK_CODE);
                end
            end else if (n_pos >= NATIVE_HDR) begin
                res_kind           = KIND_NATIVE;
                res_first_word     = n_lead;
                res_second_word    = n_word_b;
                res_trailing_count = n_pos - NATIVE_HDR;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // parse state, cleared after each final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_load) begin
            r_pos    <= '0;
            r_lead   <= '0;
            r_addr   <= '0;
            r_ser    <= '0;
            r_word_a <= '0;
            r_word_b <= '0;
            r_ctl    <= '0;
            r_dfun   <= '0;
            r_seq    <= '0;
            r_sfun   <= '0;
            r_nsb    <= '0;
        end else if (advance) begin
            r_pos    <= n_pos;
            r_lead   <= n_lead;
            r_addr   <= n_addr;
            r_ser    <= n_ser;
            r_word_a <= n_word_a;
            r_word_b <= n_word_b;
            r_ctl    <= n_ctl;
            r_dfun   <= n_dfun;
            r_seq    <= n_seq;
            r_sfun   <= n_sfun;
            r_nsb    <= n_nsb;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind            <= res_kind;
            r_node_address    <= res_node_address;
            r_serial_number   <= res_serial_number;
            r_first_word      <= res_first_word;
            r_second_word     <= res_second_word;
            r_control_byte    <= res_control_byte;
            r_dest_function   <= res_dest_function;
            r_sequence_number <= res_sequence_number;
            r_src_function    <= res_src_function;
            r_node_status     <= res_node_status;
            r_trailing_count  <= res_trailing_count;
            r_nak_seen        <= res_nak_seen;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_frame_kind      = r_kind;
    assign o_node_address    = r_node_address;
    assign o_serial_number   = r_serial_number;
    assign o_first_word      = r_first_word;
    assign o_second_word     = r_second_word;
    assign o_control_byte    = r_control_byte;
    assign o_dest_function   = r_dest_function;
    assign o_sequence_number = r_sequence_number;
    assign o_src_function    = r_src_function;
    assign o_node_status     = r_node_status;
    assign o_trailing_count  = r_trailing_count;
    assign o_nak_seen        = r_nak_seen;

    `BSAP_ASSERT_NOW(a_short_is_empty,
        r_out_valid && (r_kind == KIND_SHORT),
        (r_trailing_count == '0) && (r_first_word == '0) && !r_nak_seen,
        "too-short result carries header data")
    `BSAP_ASSERT_NOW(a_native_no_nak,
        r_out_valid && (r_kind == KIND_NATIVE),
        !r_nak_seen && (r_dest_function == '0) && (r_node_address == '0),
        "native result carries tunnel fields")
    `BSAP_ASSERT_NEXT(a_clear_after_last,
        out_load,
        (r_pos == '0) && (r_lead == '0) && r_out_valid,
        "parse state not cleared after final byte")
    `BSAP_ASSERT_NOW(a_stall_needs_pending,
        o_stall,
        r_in_valid && r_in_last && r_out_valid && i_stall,
        "input stalled without a blocked final byte")

endmodule

FILE: bench/tb_bsap_header_extractor.sv
module tb_bsap_header_extractor;
    import bsap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum {
        SHAPE_NATIVE,
        SHAPE_LOCAL,
        SHAPE_GLOBAL,
        SHAPE_NOISE
    } t_frame_shape;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_payload_byte;

    typedef struct {
        t_kind       kind;
        logic [6:0]  node_address;
        logic [7:0]  serial_number;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [7:0]  control_byte;
        logic [7:0]  dest_function;
        logic [15:0] sequence_number;
        logic [7:0]  src_function;
        logic [7:0]  node_status;
        logic [15:0] trailing_count;
        logic        nak_seen;
    } t_hdr_fields;

    typedef struct {
        logic [15:0] pos;
        logic [15:0] lead;
        logic [7:0]  addr;
        logic [7:0]  ser;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [7:0]  ctl;
        logic [7:0]  dfun;
        logic [15:0] seq;
        logic [7:0]  sfun;
        logic [7:0]  nsb;
    } t_parse_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_frame_kind;
    logic [6:0]  o_node_address;
    logic [7:0]  o_serial_number;
    logic [15:0] o_first_word;
    logic [15:0] o_second_word;
    logic [7:0]  o_control_byte;
    logic [7:0]  o_dest_function;
    logic [15:0] o_sequence_number;
    logic [7:0]  o_src_function;
    logic [7:0]  o_node_status;
    logic [15:0] o_trailing_count;
    logic        o_nak_seen;

    t_payload_byte pending_bytes[$];
    t_hdr_fields   expected_headers[$];
    t_parse_state  parser = '{default: '0};

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    int hold_left = 0;
    int err_count = 0;
    int cycle_count = 0;

    bsap_header_extractor u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_kind      (o_frame_kind),
        .o_node_address    (o_node_address),
        .o_serial_number   (o_serial_number),
        .o_first_word      (o_first_word),
        .o_second_word     (o_second_word),
        .o_control_byte    (o_control_byte),
        .o_dest_function   (o_dest_function),
        .o_sequence_number (o_sequence_number),
        .o_src_function    (o_src_function),
        .o_node_status     (o_node_status),
        .o_trailing_count  (o_trailing_count),
        .o_nak_seen        (o_nak_seen)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // header parse of one accepted byte; a final byte yields the expected header
    task automatic parse_byte(input logic [7:0] b, input logic last);
        t_hdr_fields r;
        logic [15:0] hdr_len;
        logic        glob;
        if (parser.pos == 16'd0) parser.lead[7:0] = b;
        else if (parser.pos == 16'd1) parser.lead[15:8] = b;
        else if (parser.lead != TUNNEL_MAGIC) begin
            if (parser.pos == 16'd2) parser.word_b[7:0] = b;
            else if (parser.pos == 16'd3) parser.word_b[15:8] = b;
        end else if (parser.pos == 16'd2) parser.addr = b;
        else if (parser.pos == 16'd3) parser.ser = b;
        else if (parser.addr[GLOBAL_BIT]) begin
            case (parser.pos)
                16'd4: parser.word_a[7:0] = b;
                16'd5: parser.word_a[15:8] = b;
                16'd6: parser.word_b[7:0] = b;
                16'd7: parser.word_b[15:8] = b;
                16'd8: parser.ctl = b;
                16'd9: parser.dfun = b;
                16'd10: parser.seq[7:0] = b;
                16'd11: parser.seq[15:8] = b;
                16'd12: parser.sfun = b;
                16'd13: parser.nsb = b;
                default: ;
            endcase
        end else begin
            case (parser.pos)
                16'd4: parser.dfun = b;
                16'd5: parser.seq[7:0] = b;
                16'd6: parser.seq[15:8] = b;
                16'd7: parser.sfun = b;
                16'd8: parser.nsb = b;
                default: ;
            endcase
        end
        if (parser.pos != MAX_PAYLOAD_BYTES) parser.pos++;
        if (last) begin
            r = '{default: '0};
            glob = parser.addr[GLOBAL_BIT];
            hdr_len = glob ? GLOBAL_HDR : LOCAL_HDR;
            if (parser.pos >= LEAD_LEN) begin
                if (parser.lead == TUNNEL_MAGIC) begin
                    if (parser.pos >= hdr_len) begin
                        r.kind = glob ? KIND_GLOBAL : KIND_LOCAL;
                        r.node_address = parser.addr[6:0];
                        r.serial_number = parser.ser;
                        if (glob) begin
                            r.first_word = parser.word_a;
                            r.second_word = parser.word_b;
                            r.control_byte = parser.ctl;
                        end
                        r.dest_function = parser.dfun;
                        r.sequence_number = parser.seq;
                        r.src_function = parser.sfun;
                        r.node_status = parser.nsb;
                        r.trailing_count = parser.pos - hdr_len;
                        r.nak_seen = (parser.dfun == NAK_CODE) || (parser.sfun == NAK_CODE);
                    end
                end else if (parser.pos >= NATIVE_HDR) begin
                    r.kind = KIND_NATIVE;
                    r.first_word = parser.lead;
                    r.second_word = parser.word_b;
                    r.trailing_count = parser.pos - NATIVE_HDR;
                end
            end
            expected_headers.insert(expected_headers.size(), r);
            parser = '{default: '0};
        end
    endtask

    task automatic check_header(input t_hdr_fields got, input t_hdr_fields want);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("frame_kind got %0d want %0d", got.kind, want.kind));
        if (got.node_address !== want.node_address)
            report_mismatch($sformatf("node_address got %0h want %0h",
                got.node_address, want.node_address));
        if (got.serial_number !== want.serial_number)
            report_mismatch($sformatf("serial_number got %0h want %0h",
                got.serial_number, want.serial_number));
        if (got.first_word !== want.first_word)
            report_mismatch($sformatf("first_word got %0h want %0h",
                got.first_word, want.first_word));
        if (got.second_word !== want.second_word)
            report_mismatch($sformatf("second_word got %0h want %0h",
                got.second_word, want.second_word));
        if (got.control_byte !== want.control_byte)
            report_mismatch($sformatf("control_byte got %0h want %0h",
                got.control_byte, want.control_byte));
        if (got.dest_function !== want.dest_function)
            report_mismatch($sformatf("dest_function got %0h want %0h",
                got.dest_function, want.dest_function));
        if (got.sequence_number !== want.sequence_number)
            report_mismatch($sformatf("sequence_number got %0h want %0h",
                got.sequence_number, want.sequence_number));
        if (got.src_function !== want.src_function)
            report_mismatch($sformatf("src_function got %0h want %0h",
                got.src_function, want.src_function));
        if (got.node_status !== want.node_status)
            report_mismatch($sformatf("node_status got %0h want %0h",
                got.node_status, want.node_status));
        if (got.trailing_count !== want.trailing_count)
            report_mismatch($sformatf("trailing_count got %0d want %0d",
                got.trailing_count, want.trailing_count));
        if (got.nak_seen !== want.nak_seen)
            report_mismatch($sformatf("nak_seen got %0b want %0b", got.nak_seen, want.nak_seen));
    endtask

    // fill < 0 means random content, otherwise every free byte takes that value
    task automatic queue_frame(input t_frame_shape shape, input int len, input int fill,
                               input bit nak_dst, input bit nak_src);
        t_payload_byte it;
        logic [7:0]    b;
        logic [7:0]    lead_lo;
        int            dst_at;
        int            src_at;
        int            i;
        dst_at = (shape == SHAPE_GLOBAL) ? 9 : 4;
        src_at = (shape == SHAPE_GLOBAL) ? 12 : 7;
        lead_lo = 8'h00;
        for (i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            case (shape)
                SHAPE_NATIVE: begin
                    // lead words close to the magic, but never the magic itself
                    if (i == 0 && fill < 0 && $urandom_range(1) == 0) b = TUNNEL_MAGIC[7:0];
                    if (i == 0) lead_lo = b;
                    if (i == 1 && {b, lead_lo} == TUNNEL_MAGIC) b = b ^ 8'h01;
                end
                SHAPE_LOCAL, SHAPE_GLOBAL: begin
                    if (i == 0) b = TUNNEL_MAGIC[7:0];
                    else if (i == 1) b = TUNNEL_MAGIC[15:8];
                    else if (i == 2) b = {shape == SHAPE_GLOBAL, b[6:0]};
                    else if (i == dst_at && nak_dst) b = NAK_CODE;
                    else if (i == src_at && nak_src) b = NAK_CODE;
                end
                default: ;
            endcase
            it.data = b;
            it.last = (i == len - 1);
            pending_bytes.insert(pending_bytes.size(), it);
        end
    endtask

    task automatic queue_random(input int n_bytes);
        t_frame_shape shape;
        int queued;
        int len;
        int hdr;
        int r;
        queued = 0;
        while (queued < n_bytes) begin
            r = $urandom_range(99);
            if (r < 35) shape = SHAPE_GLOBAL;
            else if (r < 65) shape = SHAPE_LOCAL;
            else if (r < 85) shape = SHAPE_NATIVE;
            else shape = SHAPE_NOISE;
            case (shape)
                SHAPE_GLOBAL: hdr = int'(GLOBAL_HDR);
                SHAPE_LOCAL:  hdr = int'(LOCAL_HDR);
                default:      hdr = int'(NATIVE_HDR);
            endcase
            if (shape == SHAPE_NOISE) len = $urandom_range(1, 16);
            else if ($urandom_range(9) == 0) len = $urandom_range(1, hdr - 1);
            else len = hdr + $urandom_range(0, 8);
            queue_frame(shape, len, -1, $urandom_range(3) == 0, $urandom_range(3) == 0);
            queued += len;
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || i_valid || expected_headers.size() != 0)
            @(negedge i_clk);
    endtask

    // driver: one request per accept edge, held while stalled
    always @(posedge i_clk) begin : byte_driver
        t_payload_byte it;
        bit            took;
        took = i_rst_n && i_valid && !o_stall;
        if (took) parse_byte(i_data_byte, i_last_byte);
        if (!i_rst_n || (i_valid && !took)) begin
        end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_bytes.pop_front();
            i_valid <= 1'b1;
            i_data_byte <= it.data;
            i_last_byte <= it.last;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin : header_monitor
        t_hdr_fields got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind = o_frame_kind;
            got.node_address = o_node_address;
            got.serial_number = o_serial_number;
            got.first_word = o_first_word;
            got.second_word = o_second_word;
            got.control_byte = o_control_byte;
            got.dest_function = o_dest_function;
            got.sequence_number = o_sequence_number;
            got.src_function = o_src_function;
            got.node_status = o_node_status;
            got.trailing_count = o_trailing_count;
            got.nak_seen = o_nak_seen;
            if (expected_headers.size() == 0)
                report_mismatch("result with no request pending");
            else
                check_header(got, expected_headers.pop_front());
        end
    end

    // receiver stall, with one long hold counted here
    always @(posedge i_clk) begin : receiver_stall
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            i_stall <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("bsap_header_extractor test failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single byte, short native, all-ones native, local and global with naks
        queue_frame(SHAPE_NOISE, 1, 8'hFF, 1'b0, 1'b0);
        queue_frame(SHAPE_NATIVE, 3, 8'h00, 1'b0, 1'b0);
        queue_frame(SHAPE_NATIVE, 4, 8'hFF, 1'b0, 1'b0);
        queue_frame(SHAPE_LOCAL, 9, 8'hFF, 1'b1, 1'b0);
        queue_frame(SHAPE_GLOBAL, 14, 8'hFF, 1'b0, 1'b1);
        drain();

        queue_random(300);
        drain();

        send_idle_pct = 80;
        queue_random(300);
        drain();

        send_idle_pct = 0;
        stall_pct = 80;
        queue_random(300);
        drain();

        send_idle_pct = 17;
        stall_pct = 17;
        queue_random(300);
        drain();

        // receiver holds off while short payloads keep coming, so the input backs up
        send_idle_pct = 0;
        stall_pct = 0;
        long_hold_req = 1'b1;
        repeat (40) queue_frame(SHAPE_NOISE, $urandom_range(1, 3), -1, 1'b0, 1'b0);
        queue_random(60);
        drain();

        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("bsap_header_extractor test passed");
        end else begin
            $display("bsap_header_extractor test failed");
        end
        $finish;
    end

endmodule
